// File: hdl/canfd_loopback_register_model_unit_defines.svh
// Assertion macros shared by the RTL files.
`ifndef CANFD_LOOPBACK_REGISTER_MODEL_UNIT_DEFINES_SVH
`define CANFD_LOOPBACK_REGISTER_MODEL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLRM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLRM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/clrm_pkg.sv
package clrm_pkg;

	localparam int WINDOW_WORDS   = 1608;
	localparam int FILTER_ENTRIES = 16;
	localparam int FRAME_WORDS    = 19;

	localparam int WW    = $clog2(WINDOW_WORDS);
	localparam int ENT_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
	localparam int CP_W  = $clog2(FRAME_WORDS);

	localparam logic [31:0] ID_MASK = 32'h1FFF_FFFF;
	localparam logic [31:0] TX_DONE = 32'h0000_0004;

	localparam logic [12:0] OFF_RX_SLOT = 13'h520;
	localparam logic [12:0] OFF_TX_BUF  = 13'h604;
	localparam logic [12:0] OFF_FILTER  = 13'h120;
	localparam logic [12:0] OFF_POP     = 13'h04C;
	localparam logic [12:0] OFF_TX_CTRL = 13'h070;
	localparam logic [12:0] OFF_TX_STAT = 13'h074;
	localparam logic [12:0] OFF_RX_STAT = 13'h044;
	localparam logic [12:0] OFF_G_CTRL  = 13'h018;
	localparam logic [12:0] OFF_G_STAT  = 13'h01C;
	localparam logic [12:0] OFF_C_CTRL  = 13'h004;
	localparam logic [12:0] OFF_C_STAT  = 13'h008;

	localparam logic [WW-1:0] W_RX_SLOT = WW'(OFF_RX_SLOT >> 2);
	localparam logic [WW-1:0] W_TX_BUF  = WW'(OFF_TX_BUF >> 2);
	localparam logic [WW-1:0] W_FILTER  = WW'(OFF_FILTER >> 2);
	localparam logic [WW-1:0] W_TX_STAT = WW'(OFF_TX_STAT >> 2);
	localparam logic [WW-1:0] W_RX_STAT = WW'(OFF_RX_STAT >> 2);
	localparam logic [WW-1:0] W_G_STAT  = WW'(OFF_G_STAT >> 2);
	localparam logic [WW-1:0] W_C_STAT  = WW'(OFF_C_STAT >> 2);

	localparam logic [2:0] WD_INPUT  = 3'd0;
	localparam logic [2:0] WD_CLEAR  = 3'd1;
	localparam logic [2:0] WD_TXDONE = 3'd2;
	localparam logic [2:0] WD_RDATA  = 3'd3;
	localparam logic [2:0] WD_RMW    = 3'd4;

	localparam logic [1:0] RMW_POP    = 2'd0;
	localparam logic [1:0] RMW_GLOBAL = 2'd1;
	localparam logic [1:0] RMW_CHAN   = 2'd2;
	localparam logic [1:0] RMW_RXDONE = 2'd3;

	typedef struct packed {
		logic        op;
		logic [12:0] addr;
		logic [31:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        rx_event;
	} out_item_t;

	typedef struct packed {
		logic          capture;
		logic          rd_en;
		logic          rd_from_input;
		logic [WW-1:0] rd_addr;
		logic          wr_en;
		logic          wr_to_input;
		logic [WW-1:0] wr_addr;
		logic [2:0]    wr_sel;
		logic [1:0]    rmw_kind;
		logic          flt_start;
		logic          flt_eid_load;
		logic          flt_eval;
		logic          ev_set;
		logic          load_out;
	} cmd_t;

	typedef struct packed {
		logic op_write;
		logic in_window;
		logic sel_tx_go;
		logic sel_pop;
		logic sel_gctrl;
		logic sel_cctrl;
		logic filter_pass;
		logic out_free;
	} sts_t;

	// Word address of an acceptance entry: the ID word, or the mask word when half is set.
	function automatic logic [WW-1:0] filt_word(input logic [ENT_W-1:0] ent, input logic half);
		return W_FILTER + WW'({ent, 1'b0, half});
	endfunction

endpackage

// File: hdl/clrm_dp.sv
`include "canfd_loopback_register_model_unit_defines.svh"

module clrm_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clrm_pkg::in_item_t    in_item,
	input  clrm_pkg::cmd_t        cmd,
	output clrm_pkg::sts_t        sts,
	output clrm_pkg::out_item_t   out_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata
);
	import clrm_pkg::*;

	logic [31:0] mem [WINDOW_WORDS];

	in_item_t      in_q;
	logic [31:0]   rdata_q;
	logic [31:0]   id_q;
	logic [31:0]   eid_q;
	logic          any_q;
	logic          hit_q;
	logic          ev_q;
	logic          ev_en_q;
	out_item_t     out_q;
	logic          out_valid_q;

	logic [WW-1:0] in_word;
	logic [WW-1:0] ra;
	logic [WW-1:0] wa;
	logic [31:0]   wd;
	logic [31:0]   rmw_val;
	logic [31:0]   mode_bits;
	logic [31:0]   mask_w;
	logic          active;
	logic          match;

	assign in_word = in_q.addr[WW+1:2];
	assign ra      = cmd.rd_from_input ? in_word : cmd.rd_addr;
	assign wa      = cmd.wr_to_input ? in_word : cmd.wr_addr;

	assign mode_bits = {30'd0, in_q.write_data[1:0] == 2'd2, in_q.write_data[1:0] == 2'd1};

	always_comb begin
		case (cmd.rmw_kind)
			RMW_POP:    rmw_val = (rdata_q | 32'h1) & ~32'h8;
			RMW_GLOBAL: rmw_val = (rdata_q & ~32'hB) | mode_bits;
			RMW_CHAN:   rmw_val = (rdata_q & ~32'h3) | mode_bits;
			RMW_RXDONE: rmw_val = (rdata_q & ~32'h1) | 32'h8;
			default:    rmw_val = rdata_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WD_INPUT:  wd = in_q.write_data;
			WD_CLEAR:  wd = (wa == W_RX_STAT) ? 32'h1 : 32'h0;
			WD_TXDONE: wd = TX_DONE;
			WD_RDATA:  wd = rdata_q;
			WD_RMW:    wd = rmw_val;
			default:   wd = in_q.write_data;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[ra];
		end
		if (cmd.wr_en) begin
			mem[wa] <= wd;
		end
	end

	assign mask_w = rdata_q & ID_MASK;
	assign active = |mask_w;
	assign match  = (id_q & mask_w) == (eid_q & mask_w);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_item;
		end
		if (cmd.flt_start) begin
			id_q <= rdata_q & ID_MASK;
		end
		if (cmd.flt_eid_load) begin
			eid_q <= rdata_q & ID_MASK;
		end
		if (cmd.flt_start) begin
			any_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.flt_eval) begin
			any_q <= any_q | active;
			hit_q <= hit_q | (active & match);
		end
		if (cmd.capture) begin
			ev_q <= 1'b0;
		end else if (cmd.ev_set) begin
			ev_q <= 1'b1;
		end
		if (cmd.load_out) begin
			out_q.read_data <= (!in_q.op && sts.in_window) ? rdata_q : 32'h0;
			out_q.rx_event  <= ev_q & ev_en_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_en_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ev_en_q <= cfg_wdata;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op_write    = in_q.op;
	assign sts.in_window   = int'(in_q.addr[12:2]) < WINDOW_WORDS;
	assign sts.sel_tx_go   = (in_q.addr == OFF_TX_CTRL) && in_q.write_data[0];
	assign sts.sel_pop     = in_q.addr == OFF_POP;
	assign sts.sel_gctrl   = in_q.addr == OFF_G_CTRL;
	assign sts.sel_cctrl   = in_q.addr == OFF_C_CTRL;
	assign sts.filter_pass = hit_q || !any_q;
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

	`CLRM_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_q, "A loaded result did not show as valid.")
	`CLRM_ASSERT_SAME(a_load_when_free, cmd.load_out, !out_valid_q || !out_stall, "A result was loaded over one still waiting.")

endmodule

// File: hdl/clrm_ctrl.sv
`include "canfd_loopback_register_model_unit_defines.svh"

module clrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  clrm_pkg::sts_t sts,
	output clrm_pkg::cmd_t cmd
);
	import clrm_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DECODE = 4'd2;
	localparam logic [3:0] ST_TX0    = 4'd3;
	localparam logic [3:0] ST_TXID   = 4'd4;
	localparam logic [3:0] ST_FMASK  = 4'd5;
	localparam logic [3:0] ST_FEVAL  = 4'd6;
	localparam logic [3:0] ST_FDONE  = 4'd7;
	localparam logic [3:0] ST_COPY   = 4'd8;
	localparam logic [3:0] ST_RMW    = 4'd9;
	localparam logic [3:0] ST_RESP   = 4'd10;

	localparam logic [WW-1:0]    CLR_LAST = WW'(WINDOW_WORDS - 1);
	localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(FILTER_ENTRIES - 1);
	localparam logic [CP_W-1:0]  CP_LAST  = CP_W'(FRAME_WORDS - 1);

	logic [3:0]       state_q, state_d;
	logic [WW-1:0]    clr_q, clr_d;
	logic [ENT_W-1:0] ent_q, ent_d;
	logic [CP_W-1:0]  cp_q, cp_d;
	logic [1:0]       kind_q, kind_d;
	logic [WW-1:0]    rmw_target;

	always_comb begin
		case (kind_q)
			RMW_GLOBAL: rmw_target = W_G_STAT;
			RMW_CHAN:   rmw_target = W_C_STAT;
			default:    rmw_target = W_RX_STAT;
		endcase
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		clr_d   = clr_q;
		ent_d   = ent_q;
		cp_d    = cp_q;
		kind_d  = kind_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = clr_q;
				cmd.wr_sel  = WD_CLEAR;
				clr_d       = clr_q + WW'(1);
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				if (!sts.op_write) begin
					cmd.rd_en         = sts.in_window;
					cmd.rd_from_input = 1'b1;
				end else if (sts.in_window) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_to_input = 1'b1;
					cmd.wr_sel      = WD_INPUT;
					if (sts.sel_tx_go) begin
						state_d = ST_TX0;
					end else if (sts.sel_pop) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = W_RX_STAT;
						kind_d      = RMW_POP;
						state_d     = ST_RMW;
					end else if (sts.sel_gctrl) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = W_G_STAT;
						kind_d      = RMW_GLOBAL;
						state_d     = ST_RMW;
					end else if (sts.sel_cctrl) begin
						cmd.rd_en   = 1'b1;
						cmd.rd_addr = W_C_STAT;
						kind_d      = RMW_CHAN;
						state_d     = ST_RMW;
					end
				end
			end
			ST_TX0: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = W_TX_STAT;
				cmd.wr_sel  = WD_TXDONE;
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = W_TX_BUF;
				state_d     = ST_TXID;
			end
			ST_TXID: begin
				cmd.flt_start = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_addr   = filt_word('0, 1'b0);
				ent_d         = '0;
				state_d       = ST_FMASK;
			end
			ST_FMASK: begin
				cmd.flt_eid_load = 1'b1;
				cmd.rd_en        = 1'b1;
				cmd.rd_addr      = filt_word(ent_q, 1'b1);
				state_d          = ST_FEVAL;
			end
			ST_FEVAL: begin
				cmd.flt_eval = 1'b1;
				if (ent_q == ENT_LAST) begin
					state_d = ST_FDONE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = filt_word(ent_q + ENT_W'(1), 1'b0);
					ent_d       = ent_q + ENT_W'(1);
					state_d     = ST_FMASK;
				end
			end
			ST_FDONE: begin
				if (sts.filter_pass) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = W_TX_BUF;
					cp_d        = '0;
					state_d     = ST_COPY;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_COPY: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = W_RX_SLOT + WW'(cp_q);
				cmd.wr_sel  = WD_RDATA;
				cmd.rd_en   = 1'b1;
				if (cp_q == CP_LAST) begin
					cmd.rd_addr = W_RX_STAT;
					kind_d      = RMW_RXDONE;
					state_d     = ST_RMW;
				end else begin
					cmd.rd_addr = W_TX_BUF + WW'(cp_q) + WW'(1);
					cp_d        = cp_q + CP_W'(1);
				end
			end
			ST_RMW: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_addr  = rmw_target;
				cmd.wr_sel   = WD_RMW;
				cmd.rmw_kind = kind_q;
				cmd.ev_set   = kind_q == RMW_RXDONE;
				state_d      = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ent_q   <= '0;
			cp_q    <= '0;
			kind_q  <= RMW_POP;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			ent_q   <= ent_d;
			cp_q    <= cp_d;
			kind_q  <= kind_d;
		end
	end

	assign in_stall = state_q != ST_IDLE;

	`CLRM_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_q == ST_DECODE, "An accepted item was not decoded next.")
	`CLRM_ASSERT_NEXT(a_clear_ends, state_q == ST_CLEAR && clr_q == CLR_LAST, state_q == ST_IDLE, "The clearing pass did not end at the last word.")
	`CLRM_ASSERT_SAME(a_no_collide, cmd.wr_en && cmd.rd_en && !cmd.wr_to_input && !cmd.rd_from_input, cmd.wr_addr != cmd.rd_addr, "A word was read and written in the same cycle.")
	`CLRM_ASSERT_NEXT(a_resp_done, state_q == ST_RESP && sts.out_free, state_q == ST_IDLE, "The block did not return to idle after a result.")

endmodule

// File: hdl/canfd_loopback_register_model_unit.sv
// Channel   Handshake                Payload
// input     in_valid / in_stall      in_item (op, addr, write_data)
// output    out_valid / out_stall    out_item (read_data, rx_event)
// config    cfg_we                   cfg_wdata (event enable)
//
// After reset the register file is cleared one word a cycle, with input stalled; the RX status word is set to 1.
// Reads and plain writes pass through decode to the response; mode and pop writes add a
// read-modify-write step on their status word, as the register memory read is registered.
// A transmit request marks the TX status done and reads two words per acceptance entry;
// an accepted frame is then copied with one read per frame word and the RX status is updated.
// The next item is taken while a result waits on a stalled output.

module canfd_loopback_register_model_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  clrm_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output clrm_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import clrm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	clrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	clrm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// File: bench/tb_canfd_loopback_register_model_unit.sv
`timescale 1ns / 100ps

module tb_canfd_loopback_register_model_unit;
	import clrm_pkg::*;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] MODE_RESET = 2'd1;
	localparam logic [1:0] MODE_HALT  = 2'd2;

	localparam logic [31:0] RX_EMPTY     = 32'h1;
	localparam logic [31:0] RX_FLAG      = 32'h8;
	localparam logic [31:0] GSTAT_CLEAR  = 32'hB;
	localparam logic [31:0] CSTAT_CLEAR  = 32'h3;
	localparam logic [31:0] TX_GO        = 32'h1;

	localparam logic [12:0] OFF_LAST_WORD = 13'(4 * (WINDOW_WORDS - 1));
	localparam logic [12:0] OFF_OUTSIDE   = 13'(4 * WINDOW_WORDS);
	localparam logic [12:0] OFF_LAST_ID   = OFF_FILTER + 13'(16 * (FILTER_ENTRIES - 1));
	localparam logic [12:0] OFF_LAST_MASK = OFF_LAST_ID + 13'd4;

	localparam int CYCLE_LIMIT = 500000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;

	bit          calm_bus = 1'b0;
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	int          accesses_sent = 0;

	logic [31:0] regs_shadow [WINDOW_WORDS];
	logic        event_en_shadow;
	out_item_t   bus_replies [$];

	canfd_loopback_register_model_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= !calm_bus && ($urandom_range(99) < 7);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("canfd_loopback_register_model_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin : check_replies
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bus_replies.size() == 0) begin
				$error("unexpected item: read_data %h rx_event %b",
					out_item.read_data, out_item.rx_event);
				mismatches++;
			end else begin
				want = bus_replies.pop_front();
				if (out_item.read_data !== want.read_data) begin
					$error("read_data: expected %h, actual %h",
						want.read_data, out_item.read_data);
					mismatches++;
				end
				if (out_item.rx_event !== want.rx_event) begin
					$error("rx_event: expected %b, actual %b",
						want.rx_event, out_item.rx_event);
					mismatches++;
				end
			end
		end
	end

	function automatic logic [31:0] mode_status(logic [31:0] status, logic [31:0] clear,
			logic [31:0] ctrl);
		logic [31:0] s;
		s = status & ~clear;
		if (ctrl[1:0] == MODE_RESET)
			s |= 32'h1;
		else if (ctrl[1:0] == MODE_HALT)
			s |= 32'h2;
		return s;
	endfunction

	function automatic logic loop_frame();
		logic [31:0] id;
		logic [31:0] mask;
		bit          filter_armed;
		bit          hit;
		int          entry;
		filter_armed = 1'b0;
		hit = 1'b0;
		id = regs_shadow[W_TX_BUF] & ID_MASK;
		regs_shadow[W_TX_STAT] = TX_DONE;
		for (int i = 0; i < FILTER_ENTRIES; i++) begin
			entry = int'(W_FILTER) + 4 * i;
			mask = regs_shadow[entry + 1] & ID_MASK;
			if (mask != 0) begin
				filter_armed = 1'b1;
				if ((id & mask) == (regs_shadow[entry] & ID_MASK & mask))
					hit = 1'b1;
			end
		end
		if (filter_armed && !hit)
			return 1'b0;
		for (int i = 0; i < FRAME_WORDS; i++)
			regs_shadow[int'(W_RX_SLOT) + i] = regs_shadow[int'(W_TX_BUF) + i];
		regs_shadow[W_RX_STAT] = (regs_shadow[W_RX_STAT] & ~RX_EMPTY) | RX_FLAG;
		return event_en_shadow;
	endfunction

	function automatic out_item_t bus_access_reply(in_item_t a);
		out_item_t   r;
		int unsigned w;
		r = '0;
		w = a.addr >> 2;
		if (a.op == OP_READ) begin
			r.read_data = (w < WINDOW_WORDS) ? regs_shadow[w] : 32'h0;
			return r;
		end
		if (w >= WINDOW_WORDS)
			return r;
		regs_shadow[w] = a.write_data;
		case (a.addr)
			OFF_TX_CTRL: begin
				if (a.write_data[0])
					r.rx_event = loop_frame();
			end
			OFF_POP: begin
				regs_shadow[W_RX_STAT] = (regs_shadow[W_RX_STAT] | RX_EMPTY) & ~RX_FLAG;
			end
			OFF_G_CTRL: begin
				regs_shadow[W_G_STAT] = mode_status(regs_shadow[W_G_STAT], GSTAT_CLEAR,
					a.write_data);
			end
			OFF_C_CTRL: begin
				regs_shadow[W_C_STAT] = mode_status(regs_shadow[W_C_STAT], CSTAT_CLEAR,
					a.write_data);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_access(logic op, logic [12:0] addr, logic [31:0] data);
		in_item_t a;
		a.op = op;
		a.addr = addr;
		a.write_data = data;
		@(negedge clk);
		while (!calm_bus && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item <= a;
		in_valid <= 1'b1;
		bus_replies.push_back(bus_access_reply(a));
		accesses_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic bus_write(logic [12:0] addr, logic [31:0] data);
		send_access(OP_WRITE, addr, data);
	endtask

	task automatic bus_read(logic [12:0] addr);
		send_access(OP_READ, addr, $urandom());
	endtask

	task automatic settle_bus();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_event_enable(logic value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		event_en_shadow = value;
	endtask

	task automatic test_window_edges();
		bus_read(OFF_RX_STAT);
		send_access(OP_READ, 13'h0, 32'hFFFF_FFFF);
		bus_read(13'h1FFF);
		bus_write(OFF_LAST_WORD, 32'hFFFF_FFFF);
		bus_read(OFF_LAST_WORD);
		bus_write(OFF_OUTSIDE, 32'hA5A5_5A5A);
		bus_read(OFF_OUTSIDE);
		bus_read(OFF_RX_STAT + 13'd1);
	endtask

	task automatic test_mode_reflection();
		bus_write(OFF_G_STAT, 32'hFFFF_FFFF);
		bus_write(OFF_G_CTRL, 32'h1);
		bus_read(OFF_G_STAT);
		bus_write(OFF_G_CTRL, 32'hFFFF_FFFE);
		bus_read(OFF_G_STAT);
		bus_write(OFF_G_CTRL, 32'h3);
		bus_write(OFF_C_CTRL, 32'h1);
		bus_read(OFF_C_STAT);
	endtask

	task automatic test_loopback_path();
		bus_write(OFF_TX_BUF, 32'hFFFF_FFFF);
		bus_write(OFF_TX_BUF + 13'(4 * (FRAME_WORDS - 1)), 32'h1234_5678);
		bus_write(OFF_TX_CTRL, TX_GO);
		bus_read(OFF_RX_SLOT + 13'(4 * (FRAME_WORDS - 1)));
		bus_read(OFF_RX_STAT);
		bus_write(OFF_POP, 32'h0);
		bus_write(OFF_TX_CTRL, 32'h2);
		bus_write(OFF_LAST_MASK, 32'hFFFF_FFFF);
		bus_write(OFF_TX_CTRL, TX_GO);
		bus_read(OFF_TX_STAT);
		bus_write(OFF_LAST_ID, 32'h1FFF_FFFF);
		bus_write(OFF_TX_CTRL, TX_GO);
		bus_write(OFF_TX_CTRL + 13'd1, TX_GO);
		bus_read(OFF_RX_STAT);
	endtask

	task automatic test_event_disable();
		settle_bus();
		set_event_enable(1'b0);
		bus_write(OFF_TX_CTRL, 32'hFFFF_FFFF);
		bus_read(OFF_RX_STAT);
	endtask

	task automatic test_random_traffic(int count, logic enable, bit calm);
		int          target;
		int          entry;
		logic [31:0] word;
		logic [31:0] mask;
		settle_bus();
		set_event_enable(enable);
		calm_bus = calm;
		target = accesses_sent + count;
		while (accesses_sent < target) begin
			case ($urandom_range(9))
				0, 1: send_access(1'($urandom_range(1)), 13'($urandom_range(8191)),
					$urandom());
				2: begin
					if ($urandom_range(1)) begin
						bus_write(OFF_G_CTRL, $urandom());
						bus_read(OFF_G_STAT);
					end else begin
						bus_write(OFF_C_CTRL, $urandom());
						bus_read(OFF_C_STAT);
					end
				end
				3: begin
					bus_write(OFF_POP, $urandom());
					bus_read(OFF_RX_STAT);
				end
				4: bus_read(13'({$urandom_range(WINDOW_WORDS - 1), 2'b00}));
				default: begin
					repeat ($urandom_range(2)) begin
						entry = $urandom_range(FILTER_ENTRIES - 1);
						word = $urandom();
						if ($urandom_range(1))
							word = (word & 32'hE000_0000) | $urandom_range(7);
						case ($urandom_range(4))
							0: mask = 32'h0;
							1: mask = 32'hFFFF_FFFF;
							2: mask = 32'h7;
							3: mask = 32'hE000_0000;
							default: mask = $urandom();
						endcase
						bus_write(OFF_FILTER + 13'(16 * entry), word);
						bus_write(OFF_FILTER + 13'(16 * entry + 4), mask);
					end
					word = $urandom();
					if ($urandom_range(1))
						word = (word & 32'hE000_0000) | $urandom_range(7);
					bus_write(OFF_TX_BUF, word);
					repeat ($urandom_range(3))
						bus_write(OFF_TX_BUF + 13'(4 * $urandom_range(1, FRAME_WORDS - 1)),
							$urandom());
					word = $urandom();
					word[0] = ($urandom_range(9) != 0);
					bus_write(OFF_TX_CTRL, word);
					bus_read(OFF_RX_STAT);
					bus_read(OFF_RX_SLOT + 13'(4 * $urandom_range(FRAME_WORDS - 1)));
					if ($urandom_range(3) == 0)
						bus_read(OFF_TX_STAT);
				end
			endcase
		end
		calm_bus = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < WINDOW_WORDS; i++)
			regs_shadow[i] = 32'h0;
		regs_shadow[W_RX_STAT] = RX_EMPTY;
		event_en_shadow = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_window_edges();
		test_mode_reflection();
		test_loopback_path();
		test_event_disable();
		test_random_traffic(300, 1'b1, 1'b0);
		test_random_traffic(300, 1'b0, 1'b1);
		test_random_traffic(300, 1'b1, 1'b0);

		settle_bus();
		if (mismatches == 0)
			$display("canfd_loopback_register_model_unit: match");
		else
			$display("canfd_loopback_register_model_unit: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/clrm_pkg.sv
hdl/clrm_dp.sv
hdl/clrm_ctrl.sv
hdl/canfd_loopback_register_model_unit.sv
bench/tb_canfd_loopback_register_model_unit.sv
